[src/qrs_preprocess_chain_macros.svh]
// Assertion helpers for the QRS preprocess chain
`ifndef QRS_PREPROCESS_CHAIN_MACROS_SVH
`define QRS_PREPROCESS_CHAIN_MACROS_SVH

`define QRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define QRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/qrs_pkg.sv]
package qrs_pkg;
  localparam int WindowLengthDef = 38;
  localparam int SampleWidthDef  = 16;
  localparam int RawDepth        = 12;
  localparam int LpDepth         = 32;
  localparam int LpW             = 24;
  localparam int HpW             = 32;
  localparam int DerW            = 24;
  localparam int SqW             = 48;
  localparam int OutW            = 48;
  localparam int GainW           = 16;
  localparam logic [GainW-1:0] GainReset = 16'd256;

  typedef struct packed {
    logic start;
    logic clear;
    logic [2:0] step;
  } qrs_cmd_t;

  typedef struct packed {
    logic div_done;
  } qrs_sts_t;
endpackage

[src/qrs_ram.sv]
module qrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/qrs_datapath.sv]
module qrs_datapath import qrs_pkg::*; #(
  parameter int WINDOW_LENGTH = WindowLengthDef,
  parameter int SAMPLE_WIDTH  = SampleWidthDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [GainW-1:0]        gain,
  input  logic [SAMPLE_WIDTH-1:0] x_in,
  input  qrs_cmd_t                cmd,
  output qrs_sts_t                sts,
  output logic [OutW-1:0]         avg_out
);
  localparam int IdxW = $clog2(WINDOW_LENGTH + 1);
  localparam int PosW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int TotW = SqW + IdxW;
  // mean by reciprocal multiply: floor(n * Recip / 2^RecK) == floor(n / WINDOW_LENGTH)
  localparam int RecK = TotW + $clog2(WINDOW_LENGTH);
  localparam int NH   = (TotW + 1) / 2;
  localparam int MH   = (TotW + 3) / 2;
  localparam int PW   = 2 * NH + 2 * MH;
  localparam int QtW  = PW - RecK;
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecK) + 64'(WINDOW_LENGTH - 1)) / 64'(WINDOW_LENGTH);
  localparam logic [2*MH-1:0] Recip = RecipFull[2*MH-1:0];

  // steps: 1 abs diff, 2 gain multiply, 3 round/sat, 4 square, 5 push,
  // 6 second push on item 1, commit
  logic signed [SAMPLE_WIDTH-1:0] raw_r [RawDepth];
  logic signed [LpW-1:0] lp1_r, lp2_r;
  logic signed [LpW-1:0] lph_r [LpDepth];
  logic signed [HpW-1:0] hp_r, hpn_r;
  logic [IdxW-1:0] idx_r;
  logic [PosW-1:0] pos_r;
  logic [TotW-1:0] tot_r;
  logic [HpW:0]    mag_r;
  logic            neg_r;
  logic [HpW+GainW:0] prod_r;
  logic [DerW-1:0] dmag_r;
  logic [SqW-1:0]  sq_r;
  logic [WINDOW_LENGTH-1:0] vld_r;
  logic [SqW-1:0]  rd_data;
  logic [SqW-1:0]  old_sq;
  logic            twice_r;

  logic signed [LpW+2:0] lp_full;
  logic signed [LpW-1:0] lp_w;
  logic signed [HpW+6:0] hp_full;
  logic signed [HpW-1:0] hp_w;
  logic signed [HpW:0]   diff;
  logic [HpW+GainW:0]    rnd;
  logic [HpW+GainW-18:0] q;

  // window mean, four partial products
  logic [2*NH-1:0]    dn_r;
  logic [PW-1:0]      dacc_r;
  logic [1:0]         dcnt_r;
  logic               dbusy_r, ddone_r;
  logic [NH-1:0]      pa;
  logic [MH-1:0]      pb;
  logic [NH+MH-1:0]   pp;
  logic [PW-1:0]      pps;
  logic [QtW-1:0]     dq;

  function automatic logic signed [SAMPLE_WIDTH-1:0] raw_x();
    return x_in;
  endfunction

  assign lp_full = (idx_r < IdxW'(2)) ? ((LpW+3)'(raw_x()) <<< 5) :
                   (LpW+3)'(2 * lp1_r) - (LpW+3)'(lp1_r - lp1_r + lp2_r)
                   + (LpW+3)'(raw_x()) - ((LpW+3)'(raw_r[5]) <<< 1) + (LpW+3)'(raw_r[11]);
  assign lp_w = lp_full[LpW-1:0];
  assign hp_full = (idx_r == '0) ? ((HpW+7)'(lp_w) <<< 5) :
                   (HpW+7)'(hp_r) - (HpW+7)'(lp_w) + ((HpW+7)'(lph_r[15]) <<< 5)
                   - ((HpW+7)'(lph_r[16]) <<< 5) + (HpW+7)'(lph_r[31]);
  assign hp_w = hp_full[HpW-1:0];
  assign diff = (HpW+1)'(hpn_r) - (HpW+1)'(hp_r);
  assign rnd  = prod_r + (HpW+GainW+1)'(1 << 17);
  assign q    = rnd[HpW+GainW:18];

  assign old_sq = vld_r[pos_r] ? rd_data : '0;

  qrs_ram #(.Width(SqW), .Depth(WINDOW_LENGTH)) u_win (
    .clk(clk), .we(cmd.step == 3'd5 || (cmd.step == 3'd6 && twice_r)),
    .waddr(pos_r), .wdata(sq_r), .raddr(pos_r), .rdata(rd_data));

  assign pa = dcnt_r[0] ? dn_r[2*NH-1:NH] : dn_r[NH-1:0];
  assign pb = dcnt_r[1] ? Recip[2*MH-1:MH] : Recip[MH-1:0];
  assign pp = (NH+MH)'(pa) * (NH+MH)'(pb);

  always_comb begin
    case (dcnt_r)
      2'd0: pps = PW'(pp);
      2'd1: pps = PW'(pp) << NH;
      2'd2: pps = PW'(pp) << MH;
      default: pps = PW'(pp) << (NH + MH);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; pos_r <= '0; tot_r <= '0; vld_r <= '0; hp_r <= '0;
      lp1_r <= '0; lp2_r <= '0; twice_r <= 1'b0;
      for (int i = 0; i < RawDepth; i++) raw_r[i] <= '0;
      for (int i = 0; i < LpDepth; i++) lph_r[i] <= '0;
    end else begin
      if (cmd.clear) begin
        idx_r <= '0; pos_r <= '0; tot_r <= '0; vld_r <= '0; hp_r <= '0;
        lp1_r <= '0; lp2_r <= '0;
        for (int i = 0; i < RawDepth; i++) raw_r[i] <= '0;
        for (int i = 0; i < LpDepth; i++) lph_r[i] <= '0;
      end else if (cmd.start) begin
        hpn_r <= hp_w;
        twice_r <= (idx_r == IdxW'(1));
        for (int i = RawDepth-1; i > 0; i--) raw_r[i] <= raw_r[i-1];
        raw_r[0] <= raw_x();
        for (int i = LpDepth-1; i > 0; i--) lph_r[i] <= lph_r[i-1];
        lph_r[0] <= lp_w;
        lp2_r <= lp1_r; lp1_r <= lp_w;
      end else begin
        case (cmd.step)
          3'd1: begin
            neg_r <= diff[HpW];
            mag_r <= diff[HpW] ? (HpW+1)'(-diff) : (HpW+1)'(diff);
          end
          3'd2: prod_r <= (HpW+GainW+1)'(mag_r) * (HpW+GainW+1)'(gain);
          3'd3: begin
            if (neg_r) dmag_r <= (q > (HpW+GainW-17)'(24'h800000)) ? 24'h800000 : DerW'(q);
            else dmag_r <= (q > (HpW+GainW-17)'(24'h7fffff)) ? 24'h7fffff : DerW'(q);
          end
          3'd4: sq_r <= SqW'(dmag_r) * SqW'(dmag_r);
          3'd5: begin
            if (idx_r != '0) begin
              tot_r <= tot_r - TotW'(old_sq) + TotW'(sq_r);
              vld_r[pos_r] <= 1'b1;
              pos_r <= (pos_r == PosW'(WINDOW_LENGTH-1)) ? '0 : pos_r + 1'b1;
            end
          end
          3'd6: begin
            if (twice_r) begin
              tot_r <= tot_r - TotW'(old_sq) + TotW'(sq_r);
              vld_r[pos_r] <= 1'b1;
              pos_r <= (pos_r == PosW'(WINDOW_LENGTH-1)) ? '0 : pos_r + 1'b1;
            end
            hp_r <= hpn_r;
            if (idx_r < IdxW'(WINDOW_LENGTH)) idx_r <= idx_r + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; ddone_r <= 1'b0;
    end else if (cmd.start && !cmd.clear && idx_r >= IdxW'(WINDOW_LENGTH)) begin
      dn_r <= (2*NH)'(tot_r); dacc_r <= '0; dcnt_r <= '0;
      dbusy_r <= 1'b1; ddone_r <= 1'b0;
    end else if (dbusy_r) begin
      dacc_r <= dacc_r + pps;
      dcnt_r <= dcnt_r + 1'b1;
      if (dcnt_r == 2'd3) begin
        dbusy_r <= 1'b0; ddone_r <= 1'b1;
      end
    end
  end

  assign dq = dacc_r[PW-1:RecK];
  assign avg_out = (dq > QtW'({OutW{1'b1}})) ? {OutW{1'b1}} : dq[OutW-1:0];
  assign sts.div_done = ddone_r;
endmodule

[src/qrs_ctrl.sv]
module qrs_ctrl import qrs_pkg::*; #(
  parameter int WINDOW_LENGTH = WindowLengthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_rs,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  output logic     out_load,
  input  qrs_sts_t sts,
  output qrs_cmd_t cmd
);
  `include "qrs_preprocess_chain_macros.svh"
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_DIV = 2'd2, S_OUT = 2'd3;
  localparam int CntW = $clog2(WINDOW_LENGTH + 1);
  logic [1:0] st_r, st_nxt;
  logic [2:0] step_r;
  logic pend_r, clr_r;
  logic [CntW-1:0] cnt_r;
  logic acc;

  assign in_stall = (st_r != S_IDLE) || clr_r;
  assign acc = in_valid && !in_stall;
  assign out_valid = (st_r == S_OUT);
  assign out_load = (st_r == S_DIV) && sts.div_done;

  always_comb begin
    cmd.clear = acc && in_rs;
    cmd.start = 1'b0;
    cmd.step = step_r;
    if (clr_r) cmd.start = 1'b1;
    if (acc && !in_rs) cmd.start = 1'b1;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (cmd.start) st_nxt = S_RUN;
      S_RUN:  if (step_r == 3'd6) st_nxt = pend_r ? S_DIV : S_IDLE;
      S_DIV:  if (sts.div_done) st_nxt = S_OUT;
      S_OUT:  if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; step_r <= '0; pend_r <= 1'b0; clr_r <= 1'b0; cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      clr_r <= acc && in_rs;
      if (acc && in_rs) cnt_r <= '0;
      if (cmd.start) begin
        step_r <= 3'd1;
        pend_r <= (cnt_r >= CntW'(WINDOW_LENGTH));
        if (cnt_r < CntW'(WINDOW_LENGTH)) cnt_r <= cnt_r + 1'b1;
      end else if (st_r == S_RUN && step_r != 3'd6) step_r <= step_r + 1'b1;
      else if (st_r == S_RUN) step_r <= '0;
    end
  end

  `QRS_ASSERT_IMP(a_no_take_busy, st_r != S_IDLE, in_stall, "input taken while busy")
  `QRS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "output dropped")
  `QRS_ASSERT_IMP(a_out_ready, st_r == S_OUT, sts.div_done, "output without a mean")
endmodule

[src/qrs_preprocess_chain.sv]
// QRS preprocess chain: low-pass, high-pass, derivative, squaring, moving mean.
// Input channel: in_valid / in_stall with in_sample, in_record_start.
// A transaction is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with out_window_average.
// cfg_we writes cfg_data to the derivative gain (Q8.8); write only when idle.
// The step sequencer runs an accepted item through its steps before the next
// accept is possible; a record start first clears the history. Items at or
// past the window length also feed the window total to a reciprocal
// multiply that overlaps the steps; the mean sits in the output register
// until out_stall is low. Earlier items in a record give no output
// transaction. The next input is taken only once the previous result is
// delivered. Reset (rst_n low, synchronous) clears all history, sets gain
// to 1.0 and acts as a record start. The window store has valid bits, so
// no clearing pass is needed.
module qrs_preprocess_chain import qrs_pkg::*; #(
  parameter int WINDOW_LENGTH = WindowLengthDef,
  parameter int SAMPLE_WIDTH  = SampleWidthDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    in_record_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OutW-1:0]         out_window_average,
  input  logic                    cfg_we,
  input  logic [GainW-1:0]        cfg_data
);
  logic [GainW-1:0] gain_r;
  logic [SAMPLE_WIDTH-1:0] x_r;
  qrs_cmd_t cmd;
  qrs_sts_t sts;
  logic out_load;
  logic [OutW-1:0] avg;
  logic [OutW-1:0] out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) gain_r <= GainReset;
    else if (cfg_we) gain_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) x_r <= in_sample;
    if (out_load) out_r <= avg;
  end

  qrs_ctrl #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_rs(in_record_start),
    .in_stall(in_stall), .out_stall(out_stall), .out_valid(out_valid),
    .out_load(out_load), .sts(sts), .cmd(cmd));

  qrs_datapath #(.WINDOW_LENGTH(WINDOW_LENGTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .gain(gain_r),
    .x_in((in_valid && !in_stall) ? in_sample : x_r),
    .cmd(cmd), .sts(sts), .avg_out(avg));

  assign out_window_average = out_r;
endmodule

[dv/qrs_preprocess_chain_tb.sv]
`timescale 1ns / 1ps
module qrs_preprocess_chain_tb import qrs_pkg::*; ();

  localparam int WinLen = 38;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_sample = '0;
  logic in_record_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OutW-1:0] out_window_average;
  logic cfg_we = 1'b0;
  logic [GainW-1:0] cfg_data = '0;

  qrs_preprocess_chain dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_record_start(in_record_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_window_average(out_window_average),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0] gain_q88;
  longint raw_hist[RawDepth];
  longint lp_prev1, lp_prev2;
  longint lp_hist[LpDepth];
  longint hp_prev;
  longint sq_ring[WinLen];
  int ring_pos;
  longint ring_sum;
  int rec_index;

  logic [OutW-1:0] expected_avg_q[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int out_hold = 0;
  bit out_idle_enable = 1'b1;

  function automatic longint wrap_to(longint v, int bits);
    longint m;
    m = (longint'(1) << bits) - 1;
    v = v & m;
    if (v[bits-1]) v = v - (longint'(1) << bits);
    return v;
  endfunction

  function automatic void clear_predictor();
    foreach (raw_hist[i]) raw_hist[i] = 0;
    foreach (lp_hist[i]) lp_hist[i] = 0;
    foreach (sq_ring[i]) sq_ring[i] = 0;
    lp_prev1 = 0; lp_prev2 = 0; hp_prev = 0;
    ring_pos = 0; ring_sum = 0; rec_index = 0;
  endfunction

  function automatic void push_sq(longint v);
    ring_sum = ring_sum - sq_ring[ring_pos] + v;
    sq_ring[ring_pos] = v;
    ring_pos = (ring_pos + 1) % WinLen;
  endfunction

  function automatic void predict_average(logic [15:0] smp, logic rs);
    longint x, lp, hp, diff, mag, avg;
    bit neg;
    if (rs) clear_predictor();
    x = longint'($signed(smp));
    if (rec_index < 2) lp = 32 * x;
    else lp = 2 * lp_prev1 - lp_prev2 + x - 2 * raw_hist[5] + raw_hist[11];
    lp = wrap_to(lp, LpW);
    if (rec_index == 0) hp = 32 * lp;
    else hp = hp_prev - lp + 32 * lp_hist[15] - 32 * lp_hist[16] + lp_hist[31];
    hp = wrap_to(hp, HpW);
    if (rec_index >= WinLen) begin
      avg = ring_sum / WinLen;
      if (avg > 64'hFFFF_FFFF_FFFF) avg = 64'hFFFF_FFFF_FFFF;
      expected_avg_q.push_back(avg[OutW-1:0]);
    end
    if (rec_index >= 1) begin
      diff = hp - hp_prev;
      neg = diff < 0;
      mag = neg ? -diff : diff;
      mag = (mag * longint'(gain_q88) + (longint'(1) << 17)) >>> 18;
      if (neg && mag > 64'h800000) mag = 64'h800000;
      if (!neg && mag > 64'h7FFFFF) mag = 64'h7FFFFF;
      if (rec_index == 1) push_sq(mag * mag);
      push_sq(mag * mag);
    end
    for (int i = RawDepth - 1; i > 0; i--) raw_hist[i] = raw_hist[i-1];
    raw_hist[0] = x;
    for (int i = LpDepth - 1; i > 0; i--) lp_hist[i] = lp_hist[i-1];
    lp_hist[0] = lp;
    lp_prev2 = lp_prev1; lp_prev1 = lp; hp_prev = hp;
    if (rec_index < WinLen) rec_index++;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  bit in_idle_enable = 1'b1;

  // valid stays high after an accept until the next gap or drain drops it
  task automatic send_sample(logic [15:0] smp, logic rs);
    int g;
    g = in_idle_enable ? rand_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    in_record_start <= rs;
    do @(posedge clk); while (in_stall);
    predict_average(smp, rs);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_avg_q.size() == 0) begin
        $error("unexpected transaction: window_average=%0d", out_window_average);
        fail_count++;
      end else begin
        logic [OutW-1:0] e;
        e = expected_avg_q.pop_front();
        if (out_window_average !== e) begin
          $error("window_average: expected %0d actual %0d", e, out_window_average);
          fail_count++;
        end
      end
    end
    if (out_hold == 0 && out_idle_enable && $urandom_range(0, 99) < 30)
      out_hold = rand_gap() + 1;
    out_stall <= (out_hold != 0);
    if (out_hold != 0) out_hold = out_hold - 1;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_avg_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_gain(logic [15:0] g);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_q88 = g;
  endtask

  function automatic logic [15:0] rand_ecg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r < 4) return 16'($urandom);
    return 16'($signed($urandom_range(0, 800)) - 400);
  endfunction

  task automatic test_directed_extremes();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    for (int i = 0; i < 20; i++) send_sample(i[0] ? 16'h7FFF : 16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
  endtask

  task automatic test_full_window(logic [15:0] g, int n);
    write_gain(g);
    send_sample(rand_ecg(), 1'b1);
    for (int i = 1; i < n; i++) send_sample(rand_ecg(), 1'b0);
  endtask

  task automatic test_random_records(int n);
    for (int i = 0; i < n; i++)
      send_sample(rand_ecg(), ($urandom_range(0, 199) == 0));
  endtask

  initial begin
    gain_q88 = GainReset;
    clear_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_full_window(16'd0, 60);
    test_full_window(16'hFFFF, 80);
    test_full_window(16'h0001, 60);
    in_idle_enable = 1'b0;
    out_idle_enable = 1'b0;
    test_full_window(16'd256, 60);
    in_idle_enable = 1'b1;
    out_idle_enable = 1'b1;
    write_gain(16'($urandom));
    test_random_records(500);
    write_gain(16'h0200);
    test_random_records(600);
    wait_drained();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
